/* rtl/core/gas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, codes and helpers of the grid A* search block.
// ----------------------------------------------------------------------------
package gas_pkg;

  // coordinate, cost and score widths (sizes are at most 63 by 63)
  localparam int CRD_W = 6;
  localparam int G_W   = 12;
  localparam int H_W   = 7;
  localparam int S_W   = 13;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

  // request kinds (the spare code reads like a read)
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // cell marks
  localparam logic [2:0] MARK_EMPTY    = 3'd0;
  localparam logic [2:0] MARK_OBSTACLE = 3'd1;
  localparam logic [2:0] MARK_EXPANDED = 3'd2;
  localparam logic [2:0] MARK_QUEUED   = 3'd3;
  localparam logic [2:0] MARK_START    = 3'd4;
  localparam logic [2:0] MARK_GOAL     = 3'd5;

  // neighbour directions, in visiting order
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic [5:0] rows;
    logic [5:0] cols;
    logic [4:0] start_row;
    logic [4:0] start_col;
    logic [4:0] goal_row;
    logic [4:0] goal_col;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] row;
    logic [4:0] col;
    logic       obstacle;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] cell_mark;
    logic       found;
  } res_t;

  typedef struct packed {
    logic [CRD_W-1:0] r;
    logic [CRD_W-1:0] c;
    logic [G_W-1:0]   g;
    logic [S_W-1:0]   s;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // manhattan distance to the goal
  function automatic logic [H_W-1:0] manhattan(input logic [CRD_W-1:0] r,
                                               input logic [CRD_W-1:0] c,
                                               input logic [4:0] gr,
                                               input logic [4:0] gc);
    logic [CRD_W-1:0] dr;
    logic [CRD_W-1:0] dc;
    dr = (r > {1'b0, gr}) ? r - {1'b0, gr} : {1'b0, gr} - r;
    dc = (c > {1'b0, gc}) ? c - {1'b0, gc} : {1'b0, gc} - c;
    manhattan = {1'b0, dr} + {1'b0, dc};
  endfunction

endpackage

/* rtl/core/gas_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_if
// Handshake channels of the grid A* search block.
// ----------------------------------------------------------------------------
interface gas_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] row;
  logic [4:0] col;
  logic       obstacle;
  modport source (output valid, kind, row, col, obstacle, input ready);
  modport sink   (input valid, kind, row, col, obstacle, output ready);
endinterface

interface gas_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] cell_mark;
  logic       found;
  modport source (output valid, cell_mark, found, input ready);
  modport sink   (input valid, cell_mark, found, output ready);
endinterface

interface gas_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/gas_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gas_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_seq
// Search sequencer: grid and open list memories, scan, compaction and
// neighbour expansion steps around one compare unit.
// ----------------------------------------------------------------------------
module gas_seq #(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int OPEN_DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gas_pkg::cfg_t  cfg_i,
  input  logic           cmd_valid_i,
  input  gas_pkg::cmd_t  cmd_i,
  input  logic           slot_free_i,
  output logic           ready_o,
  output gas_pkg::res_t  res_o
);

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int GAW    = $clog2(NCELLS);
  localparam int OAW    = $clog2(OPEN_DEPTH);
  localparam int CNW    = $clog2(OPEN_DEPTH + 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_GRD    = 4'd2;
  localparam logic [3:0] ST_OUT    = 4'd3;
  localparam logic [3:0] ST_INIT   = 4'd4;
  localparam logic [3:0] ST_SCAN   = 4'd5;
  localparam logic [3:0] ST_MOVE   = 4'd6;
  localparam logic [3:0] ST_EXPAND = 4'd7;
  localparam logic [3:0] ST_NB_RD  = 4'd8;
  localparam logic [3:0] ST_NB_CHK = 4'd9;

  function automatic logic [GAW-1:0] gaddr(input logic [gas_pkg::CRD_W-1:0] r,
                                           input logic [gas_pkg::CRD_W-1:0] c);
    gaddr = GAW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  logic [3:0]            state_q, state_d;
  logic [GAW:0]          clr_q, clr_d;
  logic [CNW-1:0]        cnt_q, cnt_d;
  logic [CNW-1:0]        idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [OAW-1:0]        pidx_q, pidx_d;
  logic [OAW-1:0]        best_q, best_d;
  logic [gas_pkg::S_W-1:0] best_s_q, best_s_d;
  gas_pkg::entry_t       cur_q, cur_d;
  logic [1:0]            dir_q, dir_d;
  logic                  found_q, found_d;
  logic [GAW-1:0]        rd_addr_q, rd_addr_d;
  logic                  rd_ok_q, rd_ok_d;

  // memory ports
  logic                  g_we;
  logic [GAW-1:0]        g_waddr, g_raddr;
  logic [2:0]            g_wdata, g_rdata;
  logic                  o_we;
  logic [OAW-1:0]        o_waddr, o_raddr;
  gas_pkg::entry_t       o_wdata, o_rdata;
  logic [gas_pkg::ENTRY_W-1:0] o_rdata_raw;

  gas_ram #(.WIDTH(3), .DEPTH(NCELLS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  gas_ram #(.WIDTH(gas_pkg::ENTRY_W), .DEPTH(OPEN_DEPTH)) u_open (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr),
    .wdata_i (o_wdata),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata_raw)
  );

  assign o_rdata = gas_pkg::entry_t'(o_rdata_raw);

  // grid size in use, clamped
  logic [5:0] nr, nc;
  always_comb begin
    if (cfg_i.rows == 6'd0) nr = 6'd1;
    else if (int'(cfg_i.rows) > MAX_ROWS) nr = 6'(MAX_ROWS);
    else nr = cfg_i.rows;
    if (cfg_i.cols == 6'd0) nc = 6'd1;
    else if (int'(cfg_i.cols) > MAX_COLS) nc = 6'(MAX_COLS);
    else nc = cfg_i.cols;
  end

  // neighbour of the current cell in the current direction
  logic [5:0] nb_r, nb_c;
  logic       nb_ok;
  always_comb begin
    nb_r  = cur_q.r;
    nb_c  = cur_q.c;
    nb_ok = 1'b0;
    case (dir_q)
      gas_pkg::DIR_RIGHT: begin
        nb_c  = cur_q.c + 6'd1;
        nb_ok = ({1'b0, cur_q.c} + 7'd1) < {1'b0, nc};
      end
      gas_pkg::DIR_LEFT: begin
        nb_c  = cur_q.c - 6'd1;
        nb_ok = cur_q.c != 6'd0;
      end
      gas_pkg::DIR_DOWN: begin
        nb_r  = cur_q.r + 6'd1;
        nb_ok = ({1'b0, cur_q.r} + 7'd1) < {1'b0, nr};
      end
      default: begin
        nb_r  = cur_q.r - 6'd1;
        nb_ok = cur_q.r != 6'd0;
      end
    endcase
  end

  logic [gas_pkg::G_W-1:0] nb_g;
  logic [gas_pkg::H_W-1:0] nb_h;
  logic [gas_pkg::H_W-1:0] st_h;
  assign nb_g = cur_q.g + gas_pkg::G_W'(1);
  assign nb_h = gas_pkg::manhattan(nb_r, nb_c, cfg_i.goal_row, cfg_i.goal_col);
  assign st_h = gas_pkg::manhattan({1'b0, cfg_i.start_row}, {1'b0, cfg_i.start_col},
                                   cfg_i.goal_row, cfg_i.goal_col);

  logic cmd_in_range;
  assign cmd_in_range = (int'(cmd_i.row) < MAX_ROWS) && (int'(cmd_i.col) < MAX_COLS);

  logic cur_is_goal, cur_is_start, open_room;
  assign cur_is_goal  = (cur_q.r == {1'b0, cfg_i.goal_row}) &&
                        (cur_q.c == {1'b0, cfg_i.goal_col});
  assign cur_is_start = (cur_q.r == {1'b0, cfg_i.start_row}) &&
                        (cur_q.c == {1'b0, cfg_i.start_col});
  assign open_room    = cnt_q < CNW'(OPEN_DEPTH);

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    best_d    = best_q;
    best_s_d  = best_s_q;
    cur_d     = cur_q;
    dir_d     = dir_q;
    found_d   = found_q;
    rd_addr_d = rd_addr_q;
    rd_ok_d   = rd_ok_q;
    g_we      = 1'b0;
    g_waddr   = gaddr(cur_q.r, cur_q.c);
    g_wdata   = gas_pkg::MARK_EMPTY;
    g_raddr   = rd_addr_q;
    o_we      = 1'b0;
    o_waddr   = cnt_q[OAW-1:0];
    o_wdata   = '{r: nb_r, c: nb_c, g: nb_g,
                  s: gas_pkg::S_W'(nb_g) + gas_pkg::S_W'(nb_h)};
    o_raddr   = idx_q[OAW-1:0];
    res_o     = '{valid: 1'b0, cell_mark: gas_pkg::MARK_EMPTY, found: found_q};

    case (state_q)
      // clearing pass over the grid after reset
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_q[GAW-1:0];
        clr_d   = clr_q + (GAW+1)'(1);
        if (clr_q == (GAW+1)'(NCELLS - 1)) state_d = ST_IDLE;
      end
      // accept a request
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == gas_pkg::KIND_WRITE) begin
            g_we    = cmd_in_range;
            g_waddr = gaddr({1'b0, cmd_i.row}, {1'b0, cmd_i.col});
            g_wdata = cmd_i.obstacle ? gas_pkg::MARK_OBSTACLE : gas_pkg::MARK_EMPTY;
            res_o.valid     = 1'b1;
            res_o.cell_mark = cmd_in_range ? g_wdata : gas_pkg::MARK_EMPTY;
          end else if (cmd_i.kind == gas_pkg::KIND_RUN) begin
            state_d = ST_INIT;
          end else begin
            rd_addr_d = gaddr({1'b0, cmd_i.row}, {1'b0, cmd_i.col});
            rd_ok_d   = cmd_in_range;
            state_d   = ST_GRD;
          end
        end
      end
      ST_GRD: begin
        state_d = ST_OUT;
      end
      // hand over the result once the output slot is free
      ST_OUT: begin
        res_o.valid     = slot_free_i;
        res_o.cell_mark = rd_ok_q ? g_rdata : gas_pkg::MARK_EMPTY;
        if (slot_free_i) state_d = ST_IDLE;
      end
      // push the start cell if it lies inside the grid
      ST_INIT: begin
        found_d = 1'b0;
        idx_d   = '0;
        pend_d  = 1'b0;
        if ({1'b0, cfg_i.start_row} < nr && {1'b0, cfg_i.start_col} < nc) begin
          o_we    = 1'b1;
          o_waddr = '0;
          o_wdata = '{r: {1'b0, cfg_i.start_row}, c: {1'b0, cfg_i.start_col},
                      g: '0, s: gas_pkg::S_W'(st_h)};
          g_we    = 1'b1;
          g_waddr = gaddr({1'b0, cfg_i.start_row}, {1'b0, cfg_i.start_col});
          g_wdata = gas_pkg::MARK_QUEUED;
          cnt_d   = CNW'(1);
          state_d = ST_SCAN;
        end else begin
          cnt_d     = '0;
          rd_addr_d = gaddr({1'b0, cfg_i.goal_row}, {1'b0, cfg_i.goal_col});
          rd_ok_d   = (int'(cfg_i.goal_row) < MAX_ROWS) && (int'(cfg_i.goal_col) < MAX_COLS);
          state_d   = ST_GRD;
        end
      end
      // walk the open list for the least score, later entries win ties
      ST_SCAN: begin
        if (cnt_q == '0) begin
          rd_addr_d = gaddr({1'b0, cfg_i.goal_row}, {1'b0, cfg_i.goal_col});
          rd_ok_d   = (int'(cfg_i.goal_row) < MAX_ROWS) && (int'(cfg_i.goal_col) < MAX_COLS);
          state_d   = ST_GRD;
        end else begin
          if (pend_q && (pidx_q == '0 || o_rdata.s <= best_s_q)) begin
            best_d   = pidx_q;
            best_s_d = o_rdata.s;
            cur_d    = o_rdata;
          end
          if (idx_q < cnt_q) begin
            pidx_d = idx_q[OAW-1:0];
            idx_d  = idx_q + CNW'(1);
            pend_d = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
          if (!pend_q && idx_q == cnt_q) begin
            idx_d   = CNW'(best_q) + CNW'(1);
            pend_d  = 1'b0;
            state_d = ST_MOVE;
          end
        end
      end
      // close the gap left by the taken entry
      ST_MOVE: begin
        if (pend_q) begin
          o_we    = 1'b1;
          o_waddr = pidx_q;
          o_wdata = o_rdata;
        end
        if (idx_q < cnt_q) begin
          pidx_d = OAW'(idx_q - CNW'(1));
          idx_d  = idx_q + CNW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (!pend_q && idx_q >= cnt_q) begin
          cnt_d   = cnt_q - CNW'(1);
          state_d = ST_EXPAND;
        end
      end
      // mark the taken cell
      ST_EXPAND: begin
        g_we    = 1'b1;
        g_wdata = cur_is_goal  ? gas_pkg::MARK_GOAL :
                  cur_is_start ? gas_pkg::MARK_START : gas_pkg::MARK_EXPANDED;
        dir_d   = gas_pkg::DIR_RIGHT;
        if (cur_is_goal) begin
          found_d   = 1'b1;
          rd_addr_d = gaddr(cur_q.r, cur_q.c);
          rd_ok_d   = 1'b1;
          state_d   = ST_GRD;
        end else begin
          state_d = ST_NB_RD;
        end
      end
      // fetch the neighbour's mark
      ST_NB_RD: begin
        g_raddr = gaddr(nb_r, nb_c);
        if (nb_ok) begin
          state_d = ST_NB_CHK;
        end else if (dir_q == gas_pkg::DIR_UP) begin
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      // queue an empty neighbour if the open list has room
      ST_NB_CHK: begin
        g_raddr = gaddr(nb_r, nb_c);
        if (g_rdata == gas_pkg::MARK_EMPTY && open_room) begin
          o_we    = 1'b1;
          g_we    = 1'b1;
          g_waddr = gaddr(nb_r, nb_c);
          g_wdata = gas_pkg::MARK_QUEUED;
          cnt_d   = cnt_q + CNW'(1);
        end
        if (dir_q == gas_pkg::DIR_UP) begin
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = ST_NB_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ready_o = state_q == ST_IDLE;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      dir_q   <= gas_pkg::DIR_RIGHT;
      found_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      dir_q   <= dir_d;
      found_q <= found_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    best_q    <= best_d;
    best_s_q  <= best_s_d;
    cur_q     <= cur_d;
    rd_addr_q <= rd_addr_d;
  end

endmodule

/* rtl/core/grid_astar_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_astar_search
// A* search with Manhattan heuristic on a four-connected occupancy grid.
// ----------------------------------------------------------------------------
// Channels: req_i carries requests (write cell, run search, read cell), rsp_o
// returns one result per request (cell mark and found flag), cfg_i writes the
// six setup registers and is always ready; the user is to write them
// between requests, since the block itself does not enforce it.
// A write request is handled as it is taken; its result is registered.
// A read request passes the states ST_GRD and ST_OUT through the grid memory
// read port. A run request first queues the start cell, then for each cell
// taken off the open list: a scan of the list, a compaction, a step to mark
// the cell and a check of each of the four neighbours; then it hands over the
// result. req_i.ready is low while a request is in progress.
// After reset the grid memory is swept to empty, one cell per cycle, over all
// MAX_ROWS*MAX_COLS cells; requests are held off meanwhile.
// Results sit in an output register; a new request is taken only when that
// register is free or being emptied, and read and run requests wait with
// their result until the register is free.
// ----------------------------------------------------------------------------
module grid_astar_search #(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int OPEN_DEPTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  gas_req_if.sink  req_i,
  gas_rsp_if.source rsp_o,
  gas_cfg_if.sink  cfg_i
);

  gas_pkg::cfg_t cfg_q;
  gas_pkg::cmd_t cmd;
  gas_pkg::res_t res;
  logic          seq_ready;
  logic          slot_free;
  logic          out_v_q;
  logic [2:0]    out_mark_q;
  logic          out_found_q;

  // setup registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rows: 6'd32, cols: 6'd32, start_row: '0, start_col: '0,
                 goal_row: '0, goal_col: '0};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gas_pkg::REG_ROWS:      cfg_q.rows      <= cfg_i.data;
        gas_pkg::REG_COLS:      cfg_q.cols      <= cfg_i.data;
        gas_pkg::REG_START_ROW: cfg_q.start_row <= cfg_i.data[4:0];
        gas_pkg::REG_START_COL: cfg_q.start_col <= cfg_i.data[4:0];
        gas_pkg::REG_GOAL_ROW:  cfg_q.goal_row  <= cfg_i.data[4:0];
        gas_pkg::REG_GOAL_COL:  cfg_q.goal_col  <= cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  // request side
  assign slot_free   = !out_v_q || rsp_o.ready;
  assign req_i.ready = seq_ready && slot_free;
  assign cmd = '{kind: req_i.kind, row: req_i.row, col: req_i.col,
                 obstacle: req_i.obstacle};

  gas_seq #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .OPEN_DEPTH(OPEN_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (req_i.valid && req_i.ready),
    .cmd_i       (cmd),
    .slot_free_i (slot_free),
    .ready_o     (seq_ready),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res.valid) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_mark_q  <= res.cell_mark;
      out_found_q <= res.found;
    end
  end

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.cell_mark = out_mark_q;
  assign rsp_o.found     = out_found_q;

endmodule
